// ===== src/bubf_pkg.sv =====
`default_nettype none

package bubf_pkg;

    localparam int FUNC_W = 3;
    localparam int BYTE_W = 8;
    localparam int DIV_W  = 13;

    // Output item packing, lowest bit first.
    localparam int OUT_BITS = 2 * BYTE_W + DIV_W + 4;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_RD_DATA   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_RD_STATUS = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_WR_DATA   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_WR_CMD    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RX_BYTE   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_TX_READY  = 3'd5;

    localparam logic [BYTE_W-1:0] ASCII_0 = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_9 = 8'h39;
    localparam logic [BYTE_W-1:0] STATUS_READY = 8'hFF;

    localparam int unsigned ClockHz = 20000000;
    localparam int unsigned Oversample = 16;

    localparam int unsigned DIV_300     = ClockHz / Oversample / 300 - 1;
    localparam int unsigned DIV_600     = ClockHz / Oversample / 600 - 1;
    localparam int unsigned DIV_1200    = ClockHz / Oversample / 1200 - 1;
    localparam int unsigned DIV_2400    = ClockHz / Oversample / 2400 - 1;
    localparam int unsigned DIV_4800    = ClockHz / Oversample / 4800 - 1;
    localparam int unsigned DIV_9600    = ClockHz / Oversample / 9600 - 1;
    localparam int unsigned DIV_19200   = ClockHz / Oversample / 19200 - 1;
    localparam int unsigned DIV_38400   = ClockHz / Oversample / 38400 - 1;
    localparam int unsigned DIV_125000  = ClockHz / Oversample / 125000 - 1;
    localparam int unsigned DIV_1250000 = ClockHz / Oversample / 1250000 - 1;
    localparam int unsigned DIV_250000  = ClockHz / Oversample / 250000 - 1;

    localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(DIV_250000);
    localparam logic [DIV_W-1:0] DIV_MAX   = DIV_W'(DIV_300);

    // Per-item state carried from the ring access to the output stage.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              hit;       // a ring pop took place
        logic              rx_avail;  // receive ring held data
        logic              overflow;
        logic [DIV_W-1:0]  divisor;
    } s1_ctrl_t;

    function automatic logic [DIV_W-1:0] divisor_lookup(input logic [BYTE_W-1:0] b);
        logic [DIV_W-1:0] d;
        d = DIV_W'(DIV_38400);
        if (b >= ASCII_0 && b <= ASCII_9)
        begin
            case (4'(b - ASCII_0))
                4'd0:    d = DIV_W'(DIV_300);
                4'd1:    d = DIV_W'(DIV_600);
                4'd2:    d = DIV_W'(DIV_1200);
                4'd3:    d = DIV_W'(DIV_2400);
                4'd4:    d = DIV_W'(DIV_4800);
                4'd5:    d = DIV_W'(DIV_9600);
                4'd6:    d = DIV_W'(DIV_19200);
                4'd7:    d = DIV_W'(DIV_38400);
                4'd8:    d = DIV_W'(DIV_125000);
                4'd9:    d = DIV_W'(DIV_1250000);
                default: d = DIV_W'(DIV_38400);
            endcase
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== src/bubf_ring_ram.sv =====
`default_nettype none

module bubf_ring_ram #(
    parameter  int DEPTH = 256,
    parameter  int WIDTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds between reads so a stalled item keeps its byte.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/bus_uart_bridge_fifo_core.sv =====
`default_nettype none

// Bus to UART bridge with a receive ring and a transmit ring.
// Input channel s_*: one event per item. s_tuser carries the event kind
// (read data, read status, write data, write command, UART byte received,
// transmitter ready); s_tdata carries the written or received byte.
// Output channel m_*: exactly one result item per input item, in order,
// holding bus read data, transmit byte, the current baud divisor and the
// overflow flag for a push into a full ring (the push is dropped).
// Each result passes the ring read and stage register, then the output
// register. Throughput: one item per cycle while m_tready is high; each
// item does at most one ring access, and the pointers sit in flip-flops,
// so the next item can act on them at once. When m_tready is low the
// output register and the stage behind it fill and s_tready drops after
// two items; nothing is lost.
// Reset: both rings empty, divisor 4 (250000 baud); ring contents are not
// cleared and need no clearing pass.
module bus_uart_bridge_fifo_core #(
    parameter int RING_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [2:0]  s_tuser,   // [2:0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] bus_data, [8] bus_drive, [9] wait_release, [17:10] tx_byte,
    // [18] tx_valid, [31:19] baud_divisor, [32] overflow, [39:33] zero
    output logic [bubf_pkg::OUT_W-1:0] m_tdata
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

    function automatic logic [AW-1:0] next_index(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : AW'(i + 1'b1);
    endfunction

    logic [AW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [AW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [bubf_pkg::DIV_W-1:0] divisor_reg, divisor_next;

    logic                s1_valid_reg;
    bubf_pkg::s1_ctrl_t  s1_reg, s1_next;
    logic                out_valid_reg;
    logic [bubf_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    logic accept, s1_advance;
    logic rx_empty, rx_full, tx_empty, tx_full;
    logic rx_wr, rx_rd, tx_wr, tx_rd;
    logic [7:0] rx_rdata, tx_rdata;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign accept     = s_tvalid && s_tready;

    assign rx_empty = (rx_head_reg == rx_tail_reg);
    assign tx_empty = (tx_head_reg == tx_tail_reg);
    assign rx_full  = (next_index(rx_head_reg) == rx_tail_reg);
    assign tx_full  = (next_index(tx_head_reg) == tx_tail_reg);

    always_comb
    begin
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        divisor_next = divisor_reg;
        rx_wr = 1'b0;
        rx_rd = 1'b0;
        tx_wr = 1'b0;
        tx_rd = 1'b0;
        s1_next.func     = s_tuser;
        s1_next.hit      = 1'b0;
        s1_next.rx_avail = !rx_empty;
        s1_next.overflow = 1'b0;
        if (accept)
        begin
            unique case (s_tuser)
                bubf_pkg::FUNC_RD_DATA:
                begin
                    if (!rx_empty)
                    begin
                        rx_rd        = 1'b1;
                        s1_next.hit  = 1'b1;
                        rx_tail_next = next_index(rx_tail_reg);
                    end
                end
                bubf_pkg::FUNC_WR_DATA:
                begin
                    if (tx_full)
                    begin
                        s1_next.overflow = 1'b1;
                    end
                    else
                    begin
                        tx_wr        = 1'b1;
                        tx_head_next = next_index(tx_head_reg);
                    end
                end
                bubf_pkg::FUNC_WR_CMD:
                begin
                    divisor_next = bubf_pkg::divisor_lookup(s_tdata);
                end
                bubf_pkg::FUNC_RX_BYTE:
                begin
                    if (rx_full)
                    begin
                        s1_next.overflow = 1'b1;
                    end
                    else
                    begin
                        rx_wr        = 1'b1;
                        rx_head_next = next_index(rx_head_reg);
                    end
                end
                bubf_pkg::FUNC_TX_READY:
                begin
                    if (!tx_empty)
                    begin
                        tx_rd        = 1'b1;
                        s1_next.hit  = 1'b1;
                        tx_tail_next = next_index(tx_tail_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
        s1_next.divisor = divisor_next;
    end

    bubf_ring_ram #(
        .DEPTH (RING_DEPTH),
        .WIDTH (8)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (rx_wr),
        .wr_addr (rx_head_reg),
        .wr_data (s_tdata),
        .rd_en   (rx_rd),
        .rd_addr (rx_tail_reg),
        .rd_data (rx_rdata)
    );

    bubf_ring_ram #(
        .DEPTH (RING_DEPTH),
        .WIDTH (8)
    ) u_tx_ram (
        .clk     (clk),
        .wr_en   (tx_wr),
        .wr_addr (tx_head_reg),
        .wr_data (s_tdata),
        .rd_en   (tx_rd),
        .rd_addr (tx_tail_reg),
        .rd_data (tx_rdata)
    );

    // Result assembly from the stage register and the ring read data.
    always_comb
    begin
        logic [7:0] bus_data, tx_byte;
        logic       bus_drive, wait_release, tx_valid;
        bus_data     = '0;
        bus_drive    = 1'b0;
        wait_release = 1'b0;
        tx_byte      = '0;
        tx_valid     = 1'b0;
        case (s1_reg.func) inside
            bubf_pkg::FUNC_RD_DATA:
            begin
                wait_release = 1'b1;
                if (s1_reg.hit)
                begin
                    bus_data  = rx_rdata;
                    bus_drive = 1'b1;
                end
            end
            bubf_pkg::FUNC_RD_STATUS:
            begin
                wait_release = 1'b1;
                bus_drive    = 1'b1;
                bus_data     = s1_reg.rx_avail ? bubf_pkg::STATUS_READY : '0;
            end
            bubf_pkg::FUNC_WR_DATA, bubf_pkg::FUNC_WR_CMD:
            begin
                wait_release = 1'b1;
            end
            bubf_pkg::FUNC_TX_READY:
            begin
                if (s1_reg.hit)
                begin
                    tx_byte  = tx_rdata;
                    tx_valid = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        out_data_next = {
            (bubf_pkg::OUT_W - bubf_pkg::OUT_BITS)'(0),
            s1_reg.overflow, s1_reg.divisor, tx_valid, tx_byte,
            wait_release, bus_drive, bus_data
        };
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            divisor_reg   <= bubf_pkg::DIV_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            divisor_reg <= divisor_next;
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== src/bubf_checker.sv =====
`default_nettype none

module bubf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [bubf_pkg::OUT_W-1:0] m_tdata
);

    logic       bus_drive, wait_release, tx_valid, overflow;
    logic [bubf_pkg::DIV_W-1:0] baud_divisor;

    assign bus_drive    = m_tdata[8];
    assign wait_release = m_tdata[9];
    assign tx_valid     = m_tdata[18];
    assign baud_divisor = m_tdata[31:19];
    assign overflow     = m_tdata[32];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output item changed");

    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> baud_divisor <= bubf_pkg::DIV_MAX)
        else $error("baud divisor out of table range");

    a_drive_is_bus: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && bus_drive |-> wait_release && !tx_valid && !overflow)
        else $error("bus drive on a non-read item");

    a_tx_not_bus: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && tx_valid |-> !wait_release && !overflow)
        else $error("tx byte on a bus item");

    a_one_per_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("accepted item gave no result");

endmodule

bind bus_uart_bridge_fifo_core bubf_checker u_bubf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int RING_DEPTH = 256;
    localparam int RING_SLOTS = RING_DEPTH - 1;
    localparam int unsigned XTAL_HZ = 20000000;

    // same bit order as m_tdata, lowest field last
    typedef struct packed {
        logic [6:0]                 pad;
        logic                       overflow;
        logic [bubf_pkg::DIV_W-1:0] baud_divisor;
        logic                       tx_valid;
        logic [7:0]                 tx_byte;
        logic                       wait_release;
        logic                       bus_drive;
        logic [7:0]                 bus_data;
    } reply_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic [2:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [bubf_pkg::OUT_W-1:0] m_tdata;

    logic [7:0]        rx_ring_q[$];
    logic [7:0]        tx_ring_q[$];
    logic [bubf_pkg::DIV_W-1:0] divisor_now;
    reply_t            pending_replies[$];
    int                errors;
    bit                no_idle;
    int                hold_cycles;
    int                reply_gap;

    bus_uart_bridge_fifo_core #(
        .RING_DEPTH (RING_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [bubf_pkg::DIV_W-1:0] divisor_of(input int unsigned baud);
        return bubf_pkg::DIV_W'(XTAL_HZ / 16 / baud - 1);
    endfunction

    function automatic logic [bubf_pkg::DIV_W-1:0] cmd_divisor(input logic [7:0] b);
        int unsigned rates[10] = '{300, 600, 1200, 2400, 4800, 9600, 19200, 38400,
                                   125000, 1250000};
        if (b >= bubf_pkg::ASCII_0 && b <= bubf_pkg::ASCII_9)
            return divisor_of(rates[b - bubf_pkg::ASCII_0]);
        return divisor_of(38400);
    endfunction

    // advances the ring/divisor image by one event and queues the reply
    task automatic bridge_update(input logic [2:0] f, input logic [7:0] b);
        reply_t r;
        r = '0;
        case (f)
            bubf_pkg::FUNC_RD_DATA:
            begin
                r.wait_release = 1'b1;
                if (rx_ring_q.size() != 0)
                begin
                    r.bus_data  = rx_ring_q.pop_front();
                    r.bus_drive = 1'b1;
                end
            end
            bubf_pkg::FUNC_RD_STATUS:
            begin
                r.wait_release = 1'b1;
                r.bus_drive    = 1'b1;
                r.bus_data     = (rx_ring_q.size() != 0) ? bubf_pkg::STATUS_READY : 8'h00;
            end
            bubf_pkg::FUNC_WR_DATA:
            begin
                r.wait_release = 1'b1;
                if (tx_ring_q.size() == RING_SLOTS)
                    r.overflow = 1'b1;
                else
                    tx_ring_q.push_back(b);
            end
            bubf_pkg::FUNC_WR_CMD:
            begin
                r.wait_release = 1'b1;
                divisor_now    = cmd_divisor(b);
            end
            bubf_pkg::FUNC_RX_BYTE:
            begin
                if (rx_ring_q.size() == RING_SLOTS)
                    r.overflow = 1'b1;
                else
                    rx_ring_q.push_back(b);
            end
            bubf_pkg::FUNC_TX_READY:
            begin
                if (tx_ring_q.size() != 0)
                begin
                    r.tx_byte  = tx_ring_q.pop_front();
                    r.tx_valid = 1'b1;
                end
            end
            default: ;
        endcase
        r.baud_divisor = divisor_now;
        pending_replies.push_back(r);
    endtask

    task automatic send_event(input logic [2:0] f, input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        bridge_update(f, b);
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom);
    endfunction

    // empty pops, unused kinds, every baud command, byte extremes
    task automatic test_directed();
        send_event(bubf_pkg::FUNC_RD_DATA, any_byte());
        send_event(bubf_pkg::FUNC_RD_STATUS, any_byte());
        send_event(bubf_pkg::FUNC_TX_READY, any_byte());
        send_event(3'd6, 8'hFF);
        send_event(3'd7, 8'h00);
        for (int d = 0; d < 10; d++)
            send_event(bubf_pkg::FUNC_WR_CMD, 8'(bubf_pkg::ASCII_0 + d));
        send_event(bubf_pkg::FUNC_WR_CMD, 8'h00);
        send_event(bubf_pkg::FUNC_WR_CMD, 8'hFF);
        send_event(bubf_pkg::FUNC_WR_CMD, 8'(bubf_pkg::ASCII_0 - 1));
        send_event(bubf_pkg::FUNC_RX_BYTE, 8'h00);
        send_event(bubf_pkg::FUNC_RX_BYTE, 8'hFF);
        send_event(bubf_pkg::FUNC_RD_STATUS, any_byte());
        send_event(bubf_pkg::FUNC_RD_DATA, any_byte());
        send_event(bubf_pkg::FUNC_RD_DATA, any_byte());
        send_event(bubf_pkg::FUNC_WR_DATA, 8'hFF);
        send_event(bubf_pkg::FUNC_WR_DATA, 8'h00);
        send_event(bubf_pkg::FUNC_TX_READY, any_byte());
        send_event(bubf_pkg::FUNC_TX_READY, any_byte());
    endtask

    // output side parks while items keep coming; input must stall, nothing lost
    task automatic test_backpressure();
        hold_cycles = 100;
        for (int i = 0; i < 30; i++)
            send_event(3'($urandom_range(0, 5)), any_byte());
    endtask

    // both rings past full (dropped pushes), then drained past empty
    task automatic test_ring_full();
        for (int i = 0; i < RING_SLOTS + 3; i++)
        begin
            no_idle = (i < RING_SLOTS / 2);
            send_event(bubf_pkg::FUNC_RX_BYTE, any_byte());
            send_event(bubf_pkg::FUNC_WR_DATA, any_byte());
        end
        send_event(bubf_pkg::FUNC_RD_STATUS, any_byte());
        for (int i = 0; i < RING_SLOTS + 2; i++)
        begin
            no_idle = (i > RING_SLOTS / 2);
            send_event(bubf_pkg::FUNC_RD_DATA, any_byte());
            send_event(bubf_pkg::FUNC_TX_READY, any_byte());
        end
        no_idle = 1'b0;
        send_event(bubf_pkg::FUNC_RD_STATUS, any_byte());
    endtask

    task automatic test_random();
        int pick;
        logic [7:0] b;
        for (int i = 0; i < 50; i++)
        begin
            if (i % 40 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            b    = any_byte();
            if (pick < 5)
            begin
                // short burst into one ring
                for (int k = 0; k < 8; k++)
                    send_event(pick[0] ? bubf_pkg::FUNC_RX_BYTE : bubf_pkg::FUNC_WR_DATA,
                               any_byte());
            end
            else if (pick < 22)
                send_event(bubf_pkg::FUNC_RD_DATA, b);
            else if (pick < 30)
                send_event(bubf_pkg::FUNC_RD_STATUS, b);
            else if (pick < 46)
                send_event(bubf_pkg::FUNC_WR_DATA, b);
            else if (pick < 52)
                send_event(bubf_pkg::FUNC_WR_CMD, $urandom_range(0, 1) ?
                           8'(bubf_pkg::ASCII_0 + $urandom_range(0, 9)) : b);
            else if (pick < 70)
                send_event(bubf_pkg::FUNC_RX_BYTE, b);
            else if (pick < 96)
                send_event(bubf_pkg::FUNC_TX_READY, b);
            else
                send_event(3'($urandom_range(6, 7)), b);
        end
        no_idle = 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // output side: per-item random wait, plus the long hold-off when asked
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else if (reply_gap > 0)
            begin
                m_tready <= 1'b0;
                reply_gap--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item: expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("bus_data", 16'(want.bus_data), 16'(got.bus_data));
                check_field("bus_drive", 16'(want.bus_drive), 16'(got.bus_drive));
                check_field("wait_release", 16'(want.wait_release),
                            16'(got.wait_release));
                check_field("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
                check_field("tx_valid", 16'(want.tx_valid), 16'(got.tx_valid));
                check_field("baud_divisor", 16'(want.baud_divisor),
                            16'(got.baud_divisor));
                check_field("overflow", 16'(want.overflow), 16'(got.overflow));
                check_field("pad", 16'(want.pad), 16'(got.pad));
            end
            reply_gap = no_idle ? 0 : $urandom_range(0, 4);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        errors      = 0;
        no_idle     = 1'b0;
        hold_cycles = 0;
        reply_gap   = 0;
        divisor_now = bubf_pkg::DIV_W'(XTAL_HZ / 16 / 250000 - 1);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_ring_full();
        test_random();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bubf_pkg.sv
src/bubf_ring_ram.sv
src/bus_uart_bridge_fifo_core.sv
src/bubf_checker.sv
verif/tb_top.sv
